>>> rtl/midi_control_surface_tracker_unit_assert.svh
// ----------------------------------------------------------------------------
// Control surface tracker assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef MIDI_CONTROL_SURFACE_TRACKER_UNIT_ASSERT_SVH
`define MIDI_CONTROL_SURFACE_TRACKER_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define MCST_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mcst check failed");

// next-cycle implication
`define MCST_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mcst check failed");

// delayed implication
`define MCST_ASSERT_AFTER2(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
    else $error("mcst check failed");

`endif

>>> rtl/mcst_pkg.sv
// ----------------------------------------------------------------------------
// Control surface tracker package
// Codes, constants and types shared by the tracker files.
// ----------------------------------------------------------------------------
package mcst_pkg;

  // action codes of an input item
  localparam logic [1:0] ACT_MIDI  = 2'd0;
  localparam logic [1:0] ACT_FADER = 2'd1;
  localparam logic [1:0] ACT_CTRL  = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_LED_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LED_B = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LED_C = 2'd2;

  // MIDI status codes
  localparam logic [3:0] MIDI_PB_HI   = 4'hE;
  localparam logic [7:0] MIDI_CC      = 8'hB0;
  localparam logic [7:0] MIDI_NOTE_ON = 8'h90;

  // clamp limits
  localparam logic signed [15:0] FADER_MAX = 16'sh3FF0;
  localparam logic signed [9:0]  CTRL_MAX  = 10'sd127;

  // operation decoded at accept
  typedef enum logic [2:0] {
    OP_NONE      = 3'd0,
    OP_FADER_SET = 3'd1,
    OP_CTRL_SET  = 3'd2,
    OP_NOTE      = 3'd3,
    OP_FADER_ADJ = 3'd4,
    OP_CTRL_ADJ  = 3'd5
  } op_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

endpackage

>>> rtl/mcst_ifs.sv
// ----------------------------------------------------------------------------
// Control surface tracker channels
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface mcst_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        action;
  logic [7:0]        midi_status;
  logic [6:0]        midi_first;
  logic [6:0]        midi_second;
  logic [6:0]        target_index;
  logic signed [7:0] step_delta;

  modport source (output valid, action, midi_status, midi_first, midi_second,
                  target_index, step_delta, input ready);
  modport sink   (input valid, action, midi_status, midi_first, midi_second,
                  target_index, step_delta, output ready);
endinterface

interface mcst_out_if;
  logic       valid;
  logic       ready;
  logic       send_valid;
  logic [7:0] send_status;
  logic [6:0] send_first;
  logic [6:0] send_second;
  logic [6:0] led_level_a;
  logic [6:0] led_level_b;
  logic [6:0] led_level_c;

  modport source (output valid, send_valid, send_status, send_first, send_second,
                  led_level_a, led_level_b, led_level_c, input ready);
  modport sink   (input valid, send_valid, send_status, send_first, send_second,
                  led_level_a, led_level_b, led_level_c, output ready);
endinterface

>>> rtl/midi_control_surface_tracker_unit.sv
// An item is decoded and its memories read at its transfer; its result is registered
// on leaving ST_EXEC, which waits only while the previous result still waits on out_ch.ready.
// Items are taken one at a time: a new item is accepted only in ST_IDLE, after the read
// then modify-write pass over the fader and controller memories.
// Reset: clears the LED notes, LED levels and the per-entry valid bits of both
// memories at once; no clearing pass, an entry never written reads as zero.
// ----------------------------------------------------------------------------
// Control surface tracker
// Mirrors faders, controllers and LED levels of a MIDI control surface and
// emits a three-byte message when an adjust changes a stored value.
// ----------------------------------------------------------------------------
module midi_control_surface_tracker_unit #(
  parameter int unsigned FADER_COUNT      = 16,
  parameter int unsigned CONTROLLER_COUNT = 128
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [mcst_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [6:0]                     cfg_wdata,
  mcst_in_if.sink                        in_ch,
  mcst_out_if.source                     out_ch
);

  localparam int unsigned FADER_AW = (FADER_COUNT > 1) ? $clog2(FADER_COUNT) : 1;
  localparam int unsigned CTRL_AW  = (CONTROLLER_COUNT > 1) ? $clog2(CONTROLLER_COUNT) : 1;
  localparam logic [7:0]  FADER_LIM = 8'(FADER_COUNT);
  localparam logic [7:0]  CTRL_LIM  = 8'(CONTROLLER_COUNT);

  // state memories and their valid bits
  logic [13:0] fader_mem [FADER_COUNT];
  logic [6:0]  ctrl_mem  [CONTROLLER_COUNT];
  logic [FADER_COUNT-1:0]      fader_vld_r;
  logic [CONTROLLER_COUNT-1:0] ctrl_vld_r;

  mcst_pkg::state_t state_r;
  mcst_pkg::op_t    op_r, op_nxt;
  logic [FADER_AW-1:0] faddr_r, faddr_nxt;
  logic [CTRL_AW-1:0]  caddr_r, caddr_nxt;
  logic [6:0]          d1_r, d2_r;
  logic signed [7:0]   delta_r;
  logic [13:0]         fader_rd_r;
  logic [6:0]          ctrl_rd_r;
  logic                fader_rv_r, ctrl_rv_r;
  logic [6:0]          led_note_r [3];
  logic [6:0]          led_lvl_r  [3];
  logic [6:0]          led_lvl_nxt [3];

  logic       out_valid_r;
  logic       send_valid_r, send_valid_nxt;
  logic [7:0] send_status_r, send_status_nxt;
  logic [6:0] send_first_r, send_first_nxt;
  logic [6:0] send_second_r, send_second_nxt;

  logic in_fire, exec_go;
  logic fader_we, ctrl_we;
  logic [13:0] fader_wd, fader_old;
  logic [6:0]  ctrl_wd, ctrl_old;
  logic signed [15:0] fader_sum;
  logic signed [9:0]  ctrl_sum;

  assign in_ch.ready = (state_r == mcst_pkg::ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign exec_go     = (state_r == mcst_pkg::ST_EXEC) && (!out_valid_r || out_ch.ready);

  // decode the item into an operation and memory addresses
  always_comb begin
    op_nxt    = mcst_pkg::OP_NONE;
    faddr_nxt = FADER_AW'(in_ch.target_index);
    caddr_nxt = CTRL_AW'(in_ch.target_index);
    if (in_ch.action == mcst_pkg::ACT_MIDI) begin
      if (in_ch.midi_status[7:4] == mcst_pkg::MIDI_PB_HI) begin
        faddr_nxt = FADER_AW'(in_ch.midi_status[3:0]);
        if ({4'd0, in_ch.midi_status[3:0]} < FADER_LIM) op_nxt = mcst_pkg::OP_FADER_SET;
      end else if (in_ch.midi_status == mcst_pkg::MIDI_CC) begin
        caddr_nxt = CTRL_AW'(in_ch.midi_first);
        if ({1'b0, in_ch.midi_first} < CTRL_LIM) op_nxt = mcst_pkg::OP_CTRL_SET;
      end else if (in_ch.midi_status == mcst_pkg::MIDI_NOTE_ON) begin
        op_nxt = mcst_pkg::OP_NOTE;
      end
    end else if (in_ch.action == mcst_pkg::ACT_FADER) begin
      if ({1'b0, in_ch.target_index} < FADER_LIM) op_nxt = mcst_pkg::OP_FADER_ADJ;
    end else if (in_ch.action == mcst_pkg::ACT_CTRL) begin
      if ({1'b0, in_ch.target_index} < CTRL_LIM) op_nxt = mcst_pkg::OP_CTRL_ADJ;
    end
  end

  // sequencer: take an item, then write back once the result register is free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mcst_pkg::ST_IDLE;
    end else begin
      unique case (state_r)
        mcst_pkg::ST_IDLE: if (in_fire) state_r <= mcst_pkg::ST_EXEC;
        mcst_pkg::ST_EXEC: if (exec_go) state_r <= mcst_pkg::ST_IDLE;
        default:           state_r <= mcst_pkg::ST_IDLE;
      endcase
    end
  end

  // capture the item and read both memories
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r       <= op_nxt;
      faddr_r    <= faddr_nxt;
      caddr_r    <= caddr_nxt;
      d1_r       <= in_ch.midi_first;
      d2_r       <= in_ch.midi_second;
      delta_r    <= in_ch.step_delta;
      fader_rd_r <= fader_mem[faddr_nxt];
      ctrl_rd_r  <= ctrl_mem[caddr_nxt];
      fader_rv_r <= fader_vld_r[faddr_nxt];
      ctrl_rv_r  <= ctrl_vld_r[caddr_nxt];
    end
  end

  assign fader_old = fader_rv_r ? fader_rd_r : 14'd0;
  assign ctrl_old  = ctrl_rv_r ? ctrl_rd_r : 7'd0;

  // adjust with clamp
  assign fader_sum = $signed({2'b00, fader_old}) + $signed({{4{delta_r[7]}}, delta_r, 4'b0000});
  assign ctrl_sum  = $signed({3'b000, ctrl_old}) + $signed({{2{delta_r[7]}}, delta_r});

  always_comb begin
    fader_we        = 1'b0;
    ctrl_we         = 1'b0;
    fader_wd        = {d2_r, d1_r};
    ctrl_wd         = d2_r;
    send_valid_nxt  = 1'b0;
    send_status_nxt = 8'd0;
    send_first_nxt  = 7'd0;
    send_second_nxt = 7'd0;
    led_lvl_nxt     = led_lvl_r;
    unique case (op_r)
      mcst_pkg::OP_FADER_SET: fader_we = 1'b1;
      mcst_pkg::OP_CTRL_SET:  ctrl_we  = 1'b1;
      mcst_pkg::OP_NOTE: begin
        priority if (d1_r == led_note_r[0]) led_lvl_nxt[0] = d2_r;
        else if (d1_r == led_note_r[1])     led_lvl_nxt[1] = d2_r;
        else if (d1_r == led_note_r[2])     led_lvl_nxt[2] = d2_r;
        else                                led_lvl_nxt    = led_lvl_r;
      end
      mcst_pkg::OP_FADER_ADJ: begin
        fader_we = 1'b1;
        priority if (fader_sum[15])               fader_wd = 14'd0;
        else if (fader_sum > mcst_pkg::FADER_MAX) fader_wd = 14'(mcst_pkg::FADER_MAX);
        else                                      fader_wd = fader_sum[13:0];
        if (fader_wd != fader_old) begin
          send_valid_nxt  = 1'b1;
          send_status_nxt = {mcst_pkg::MIDI_PB_HI, 4'(faddr_r)};
          send_first_nxt  = fader_wd[6:0];
          send_second_nxt = fader_wd[13:7];
        end
      end
      mcst_pkg::OP_CTRL_ADJ: begin
        ctrl_we = 1'b1;
        priority if (ctrl_sum[9])               ctrl_wd = 7'd0;
        else if (ctrl_sum > mcst_pkg::CTRL_MAX) ctrl_wd = 7'(mcst_pkg::CTRL_MAX);
        else                                    ctrl_wd = ctrl_sum[6:0];
        if (ctrl_wd != ctrl_old) begin
          send_valid_nxt  = 1'b1;
          send_status_nxt = mcst_pkg::MIDI_CC;
          send_first_nxt  = 7'(caddr_r);
          send_second_nxt = ctrl_wd;
        end
      end
      default: ;
    endcase
  end

  // write back to the memories
  always_ff @(posedge clk) begin
    if (exec_go && fader_we) fader_mem[faddr_r] <= fader_wd;
    if (exec_go && ctrl_we)  ctrl_mem[caddr_r]  <= ctrl_wd;
  end

  // valid bits, LED state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fader_vld_r <= '0;
      ctrl_vld_r  <= '0;
      led_lvl_r   <= '{3{7'd0}};
      led_note_r  <= '{3{7'd0}};
    end else begin
      if (exec_go && fader_we) fader_vld_r[faddr_r] <= 1'b1;
      if (exec_go && ctrl_we)  ctrl_vld_r[caddr_r]  <= 1'b1;
      if (exec_go) led_lvl_r <= led_lvl_nxt;
      if (cfg_we) begin
        unique case (cfg_idx)
          mcst_pkg::CFG_LED_A: led_note_r[0] <= cfg_wdata;
          mcst_pkg::CFG_LED_B: led_note_r[1] <= cfg_wdata;
          mcst_pkg::CFG_LED_C: led_note_r[2] <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // result register: hold until transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  logic [6:0] led_out_r [3];

  always_ff @(posedge clk) begin
    if (exec_go) begin
      send_valid_r  <= send_valid_nxt;
      send_status_r <= send_status_nxt;
      send_first_r  <= send_first_nxt;
      send_second_r <= send_second_nxt;
      led_out_r     <= led_lvl_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.send_valid  = send_valid_r;
  assign out_ch.send_status = send_status_r;
  assign out_ch.send_first  = send_first_r;
  assign out_ch.send_second = send_second_r;
  assign out_ch.led_level_a = led_out_r[0];
  assign out_ch.led_level_b = led_out_r[1];
  assign out_ch.led_level_c = led_out_r[2];

endmodule

>>> rtl/mcst_checker.sv
// ----------------------------------------------------------------------------
// Control surface tracker checker
// Port-level properties of the tracker, bound to the top level.
// ----------------------------------------------------------------------------
`include "midi_control_surface_tracker_unit_assert.svh"

module mcst_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       send_valid,
  input logic [7:0] send_status,
  input logic [6:0] send_first,
  input logic [6:0] send_second
);

  // a stalled result stays offered
  `MCST_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  // one item at a time: busy right after a transfer
  `MCST_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready)
  // with the result register free, an accepted item's result follows without a stall
  `MCST_ASSERT_AFTER2(a_latency, in_valid && in_ready && !out_valid, out_valid)
  // no message means zero message bytes
  `MCST_ASSERT_SAME(a_quiet_zero, out_valid && !send_valid,
    send_status == 8'd0 && send_first == 7'd0 && send_second == 7'd0)
  // a message is a pitch bend or the controller change status
  `MCST_ASSERT_SAME(a_send_kind, out_valid && send_valid,
    send_status[7:4] == mcst_pkg::MIDI_PB_HI || send_status == mcst_pkg::MIDI_CC)

endmodule

bind midi_control_surface_tracker_unit mcst_checker u_mcst_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .send_valid  (out_ch.send_valid),
  .send_status (out_ch.send_status),
  .send_first  (out_ch.send_first),
  .send_second (out_ch.send_second)
);
